@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: label");

`endif

@@ hw/rtl/sph_pkg.sv @@
// types, constants and helpers for the uv sphere vertex generator
// no dependencies
package sph_pkg;

  localparam int MAX_DIVISIONS = 255;
  localparam int DIV_CELLS     = 17;
  localparam int CORDIC_STEPS  = 18;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0] Q14_ONE     = 16'sd16384;

  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_SECTORS = 2'd1;
  localparam logic [1:0] REG_STACKS  = 2'd2;

  typedef struct packed {
    logic [7:0] stack_index;
    logic [7:0] sector_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               index_clamped;
  } out_t;

  typedef struct packed {
    logic [7:0]  den;
    logic [8:0]  rem;
    logic [16:0] num;
    logic [16:0] quo;
  } div_lane_t;

  // lane 0: stack phase, lane 1: longitude phase, lane 2: tex u
  typedef struct packed {
    logic            valid;
    logic            clamped;
    div_lane_t [2:0] lane;
  } div_rec_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [23:0] z;
    logic [1:0]         quad;
  } cor_lane_t;

  // lane 0: latitude, lane 1: longitude
  typedef struct packed {
    logic            valid;
    logic            clamped;
    logic [15:0]     tex_u;
    logic [15:0]     tex_v;
    cor_lane_t [1:0] lane;
  } cor_rec_t;

  function automatic logic signed [23:0] atan_step(input logic [4:0] i);
    logic signed [23:0] a;
    case (i)
      5'd0:    a = 24'sd2097152;
      5'd1:    a = 24'sd1238021;
      5'd2:    a = 24'sd654136;
      5'd3:    a = 24'sd332050;
      5'd4:    a = 24'sd166669;
      5'd5:    a = 24'sd83416;
      5'd6:    a = 24'sd41718;
      5'd7:    a = 24'sd20860;
      5'd8:    a = 24'sd10430;
      5'd9:    a = 24'sd5215;
      5'd10:   a = 24'sd2608;
      5'd11:   a = 24'sd1304;
      5'd12:   a = 24'sd652;
      5'd13:   a = 24'sd326;
      5'd14:   a = 24'sd163;
      5'd15:   a = 24'sd81;
      5'd16:   a = 24'sd41;
      5'd17:   a = 24'sd20;
      default: a = 24'sd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sd32767;
    else if (v < -48'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/sph_div_cell.sv @@
// one restoring division step for the three quotient lanes
// depends on sph_pkg
module sph_div_cell import sph_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  div_rec_t d_in,
  output div_rec_t d_out
);

  div_rec_t d_out_next;

  always_comb begin
    logic [8:0] t;
    d_out_next = d_in;
    for (int k = 0; k < 3; k++) begin
      t = {d_in.lane[k].rem[7:0], d_in.lane[k].num[16]};
      d_out_next.lane[k].num = {d_in.lane[k].num[15:0], 1'b0};
      if (t >= {1'b0, d_in.lane[k].den}) begin
        d_out_next.lane[k].rem = t - {1'b0, d_in.lane[k].den};
        d_out_next.lane[k].quo = {d_in.lane[k].quo[15:0], 1'b1};
      end else begin
        d_out_next.lane[k].rem = t;
        d_out_next.lane[k].quo = {d_in.lane[k].quo[15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (adv) begin
      d_out <= d_out_next;
    end
  end

endmodule

@@ hw/rtl/sph_cordic_cell.sv @@
// one rotation step of the cordic for latitude and longitude lanes
// depends on sph_pkg
module sph_cordic_cell import sph_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [4:0] step,
  input  cor_rec_t   c_in,
  output cor_rec_t   c_out
);

  cor_rec_t c_out_next;

  always_comb begin
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    c_out_next = c_in;
    for (int k = 0; k < 2; k++) begin
      xs = c_in.lane[k].x >>> step;
      ys = c_in.lane[k].y >>> step;
      if (c_in.lane[k].z >= 24'sd0) begin
        c_out_next.lane[k].x = c_in.lane[k].x - ys;
        c_out_next.lane[k].y = c_in.lane[k].y + xs;
        c_out_next.lane[k].z = c_in.lane[k].z - atan_step(step);
      end else begin
        c_out_next.lane[k].x = c_in.lane[k].x + ys;
        c_out_next.lane[k].y = c_in.lane[k].y - xs;
        c_out_next.lane[k].z = c_in.lane[k].z + atan_step(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_out.valid <= 1'b0;
    end else if (adv) begin
      c_out <= c_out_next;
    end
  end

endmodule

@@ hw/rtl/uv_sphere_vertex_generator.sv @@
// uv sphere vertex generator top level: divider and cordic cell chains, products
// depends on sph_pkg, sph_div_cell, sph_cordic_cell
//
// usage:
//   in_valid/in_stall carry one grid point (stack_index, sector_index) per
//   request; out_valid/out_stall return one vertex record per request, in order.
//   registers are written through cfg_we/cfg_index/cfg_data; the user must do so
//   only while idle, the block does not enforce it. index 0 radius (Q7.8),
//   1 sector count, 2 stack count; index 3 is ignored. the pipeline has 17 divider
//   cells (one quotient bit each), 18 cordic cells (one rotation each), one rounding
//   stage, two multiplier stages and the output register. throughput is one request
//   per cycle while the receiver does not stall a valid result, as every cell
//   hands its record on whenever the pipeline advances. when the receiver stalls
//   a valid result, the whole pipeline holds and in_stall rises; bubbles
//   elsewhere never stall the input. synchronous reset empties the pipeline
//   and loads radius 256, 36 sectors and 18 stacks.
module uv_sphere_vertex_generator import sph_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  logic [14:0] sphere_radius;
  logic [7:0]  sector_count;
  logic [7:0]  stack_count;
  logic [7:0]  stacks;
  logic [7:0]  sectors;
  logic        adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 15'd256;
      sector_count  <= 8'd36;
      stack_count   <= 8'd18;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS:  sphere_radius <= cfg_data;
        REG_SECTORS: sector_count  <= cfg_data[7:0];
        REG_STACKS:  stack_count   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic [7:0] eff_count(input logic [7:0] c);
    logic [7:0] r;
    if (c == 8'd0) r = 8'd1;
    else if (c > 8'(MAX_DIVISIONS)) r = 8'(MAX_DIVISIONS);
    else r = c;
    return r;
  endfunction

  assign stacks   = eff_count(stack_count);
  assign sectors  = eff_count(sector_count);
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // front: clamp indices and load the divider lanes
  div_rec_t div_s [0:DIV_CELLS];

  always_comb begin
    logic [7:0]  st;
    logic [7:0]  se;
    logic [23:0] n0;
    logic [23:0] n1;
    logic [23:0] n2;
    st = in_data.stack_index;
    se = in_data.sector_index;
    div_s[0].clamped = 1'b0;
    if (st > stacks) begin
      st = stacks;
      div_s[0].clamped = 1'b1;
    end
    if (se > sectors) begin
      se = sectors;
      div_s[0].clamped = 1'b1;
    end
    div_s[0].valid = in_valid;
    n0 = {1'b0, st, 15'd0} + {17'd0, stacks[7:1]};
    n1 = {se, 16'd0} + {17'd0, sectors[7:1]};
    n2 = {1'b0, se, 15'd0} + {17'd0, sectors[7:1]};
    div_s[0].lane[0] = '{den: stacks,  rem: {2'b0, n0[23:17]}, num: n0[16:0], quo: '0};
    div_s[0].lane[1] = '{den: sectors, rem: {2'b0, n1[23:17]}, num: n1[16:0], quo: '0};
    div_s[0].lane[2] = '{den: sectors, rem: {2'b0, n2[23:17]}, num: n2[16:0], quo: '0};
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    sph_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .d_in (div_s[i]),
      .d_out(div_s[i+1])
    );
  end

  // phases and quarter-turn reduction
  cor_rec_t cor_s [0:CORDIC_STEPS];

  always_comb begin
    logic [15:0] ph [2];
    logic [16:0] sum;
    logic [1:0]  q;
    logic [15:0] d;
    ph[0] = 16'd16384 - div_s[DIV_CELLS].lane[0].quo[15:0];
    ph[1] = div_s[DIV_CELLS].lane[1].quo[15:0];
    cor_s[0].valid   = div_s[DIV_CELLS].valid;
    cor_s[0].clamped = div_s[DIV_CELLS].clamped;
    cor_s[0].tex_v   = div_s[DIV_CELLS].lane[0].quo[15:0];
    cor_s[0].tex_u   = div_s[DIV_CELLS].lane[2].quo[15:0];
    for (int k = 0; k < 2; k++) begin
      sum = {1'b0, ph[k]} + 17'd8192;
      q   = sum[15:14];
      d   = ph[k] - {q, 14'd0};
      cor_s[0].lane[k].quad = q;
      cor_s[0].lane[k].x    = CORDIC_GAIN;
      cor_s[0].lane[k].y    = '0;
      cor_s[0].lane[k].z    = {d, 8'd0};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    sph_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .step (5'(i)),
      .c_in (cor_s[i]),
      .c_out(cor_s[i+1])
    );
  end

  // rounding to Q1.14, clamp and quarter-turn rotation
  logic               t_valid;
  logic               t_clamped;
  logic [15:0]        t_tex_u;
  logic [15:0]        t_tex_v;
  logic signed [15:0] t_cs [2];
  logic signed [15:0] t_sn [2];
  logic signed [15:0] t_cs_next [2];
  logic signed [15:0] t_sn_next [2];

  always_comb begin
    logic signed [33:0] xr;
    logic signed [33:0] yr;
    logic signed [15:0] c;
    logic signed [15:0] s;
    for (int k = 0; k < 2; k++) begin
      xr = (cor_s[CORDIC_STEPS].lane[k].x + 34'sd32768) >>> 16;
      yr = (cor_s[CORDIC_STEPS].lane[k].y + 34'sd32768) >>> 16;
      if (xr > 34'(Q14_ONE)) c = Q14_ONE;
      else if (xr < -34'(Q14_ONE)) c = -Q14_ONE;
      else c = xr[15:0];
      if (yr > 34'(Q14_ONE)) s = Q14_ONE;
      else if (yr < -34'(Q14_ONE)) s = -Q14_ONE;
      else s = yr[15:0];
      case (cor_s[CORDIC_STEPS].lane[k].quad)
        2'd0:    begin t_cs_next[k] = c;  t_sn_next[k] = s;  end
        2'd1:    begin t_cs_next[k] = -s; t_sn_next[k] = c;  end
        2'd2:    begin t_cs_next[k] = -c; t_sn_next[k] = -s; end
        default: begin t_cs_next[k] = s;  t_sn_next[k] = -c; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv) begin
      t_valid   <= cor_s[CORDIC_STEPS].valid;
      t_clamped <= cor_s[CORDIC_STEPS].clamped;
      t_tex_u   <= cor_s[CORDIC_STEPS].tex_u;
      t_tex_v   <= cor_s[CORDIC_STEPS].tex_v;
      t_cs      <= t_cs_next;
      t_sn      <= t_sn_next;
    end
  end

  // first products: cl*co, cl*so, r*sl
  logic               m1_valid;
  logic               m1_clamped;
  logic [15:0]        m1_tex_u;
  logic [15:0]        m1_tex_v;
  logic signed [31:0] m1_pcc;
  logic signed [31:0] m1_pcs;
  logic signed [31:0] m1_pz;
  logic signed [15:0] m1_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid   <= t_valid;
      m1_clamped <= t_clamped;
      m1_tex_u   <= t_tex_u;
      m1_tex_v   <= t_tex_v;
      m1_pcc     <= 32'(t_cs[0] * t_cs[1]);
      m1_pcs     <= 32'(t_cs[0] * t_sn[1]);
      m1_pz      <= 32'($signed({1'b0, sphere_radius}) * t_sn[0]);
      m1_nz      <= t_sn[0];
    end
  end

  // second products: r*cl*co, r*cl*so; normals and z rounded here
  logic               m2_valid;
  logic               m2_clamped;
  logic [15:0]        m2_tex_u;
  logic [15:0]        m2_tex_v;
  logic signed [47:0] m2_px;
  logic signed [47:0] m2_py;
  logic signed [15:0] m2_pz;
  logic signed [15:0] m2_nx;
  logic signed [15:0] m2_ny;
  logic signed [15:0] m2_nz;
  logic signed [31:0] nx_full;
  logic signed [31:0] ny_full;
  logic signed [47:0] pz_full;

  assign nx_full = (m1_pcc + 32'sd8192) >>> 14;
  assign ny_full = (m1_pcs + 32'sd8192) >>> 14;
  assign pz_full = (48'(m1_pz) + 48'sd8192) >>> 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid   <= m1_valid;
      m2_clamped <= m1_clamped;
      m2_tex_u   <= m1_tex_u;
      m2_tex_v   <= m1_tex_v;
      m2_px      <= $signed({1'b0, sphere_radius}) * 48'(m1_pcc);
      m2_py      <= $signed({1'b0, sphere_radius}) * 48'(m1_pcs);
      m2_pz      <= sat16(pz_full);
      m2_nx      <= nx_full[15:0];
      m2_ny      <= ny_full[15:0];
      m2_nz      <= m1_nz;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid              <= m2_valid;
      out_data.pos_x         <= sat16((m2_px + 48'sd134217728) >>> 28);
      out_data.pos_y         <= sat16((m2_py + 48'sd134217728) >>> 28);
      out_data.pos_z         <= m2_pz;
      out_data.normal_x      <= m2_nx;
      out_data.normal_y      <= m2_ny;
      out_data.normal_z      <= m2_nz;
      out_data.tex_u         <= m2_tex_u;
      out_data.tex_v         <= m2_tex_v;
      out_data.index_clamped <= m2_clamped;
    end
  end

endmodule

@@ hw/rtl/sph_checker.sv @@
// port-level checks for the uv sphere vertex generator, bound to the top level
// depends on sph_pkg and assert_macros.svh
`include "assert_macros.svh"

module sph_checker import sph_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic tex_ok;

  assign tex_ok = (out_data.tex_u <= 16'd32768) && (out_data.tex_v <= 16'd32768);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data))
  `ASSERT_IMPLIES(a_no_idle_stall, clk, rst, !(out_valid && out_stall), !in_stall)
  `ASSERT_IMPLIES(a_tex_range, clk, rst, out_valid, tex_ok)
  `ASSERT_IMPLIES(a_reset_empty, clk, 1'b0, $past(rst), !out_valid)

endmodule

bind uv_sphere_vertex_generator sph_checker u_sph_checker (.*);
